FILE: design/laplacian_edge_rgb_unit_defines.svh
// assertion macros shared by the checker of the laplacian edge unit
// no dependencies
`ifndef LAPLACIAN_EDGE_RGB_UNIT_DEFINES_SVH
`define LAPLACIAN_EDGE_RGB_UNIT_DEFINES_SVH

// clocked property, off while reset is low
`define LERU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold
`define LERU_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `LERU_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

FILE: design/leru_pkg.sv
// types, constants and filter functions of the laplacian edge unit
// no dependencies
`default_nettype none

package leru_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] MIN_DIM       = DIM_W'(3);
    localparam logic [DIM_W-1:0] RESET_WIDTH   = DIM_W'(600);
    localparam logic [DIM_W-1:0] RESET_HEIGHT  = DIM_W'(400);
    localparam logic [DIM_W-1:0] MAX_WIDTH_V   = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_HEIGHT_V  = DIM_W'(MAX_HEIGHT);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

    // [row][col], row 0 oldest line, col 2 newest column
    typedef t_pix [2:0][2:0] t_win;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] col;
        t_pix              pix;
    } t_res;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v < MIN_DIM) begin
            r = MIN_DIM;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // eight times centre minus neighbours, clamped to 0..255; entry 4 is the centre
    function automatic logic [7:0] lap_chan(input logic [8:0][7:0] ch);
        logic [10:0]        nsum;
        logic signed [12:0] s;
        logic [7:0]         r;
        nsum = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                nsum = nsum + 11'(ch[k]);
            end
        end
        s = $signed({2'b00, ch[4], 3'b000}) - $signed({2'b00, nsum});
        if (s[12]) begin
            r = 8'd0;
        end else if (s > 13'sd255) begin
            r = 8'd255;
        end else begin
            r = s[7:0];
        end
        return r;
    endfunction

    function automatic t_pix laplacian(input t_win w);
        logic [8:0][7:0] cr;
        logic [8:0][7:0] cg;
        logic [8:0][7:0] cb;
        t_pix            p;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                cr[r*3+c] = w[r][c].red;
                cg[r*3+c] = w[r][c].green;
                cb[r*3+c] = w[r][c].blue;
            end
        end
        p.red   = lap_chan(cr);
        p.green = lap_chan(cg);
        p.blue  = lap_chan(cb);
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: design/laplacian_edge_rgb_unit.sv
// top level of the rgb 3x3 laplacian edge unit: line stores, window, result slots
// depends on leru_pkg
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: red, green, blue
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: rgb, col, row; tlast: run end
//  cfg       in   i_cfg_valid / o_cfg_ready      index, 11-bit data
//
// one pixel accepted per cycle while the result slots drain; a pixel is registered
// in stage one, then in the result slots, held until all its results (up to 3) are taken
// line stores are single-port-write arrays read once per accepted pixel
// synchronous active-low reset clears counters, window, valids; sets size to 600 x 400
// output stalls back up through the result slots and stage one to s_axis_tready
`default_nettype none

module laplacian_edge_rgb_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [23:0]                     s_axis_tdata,  // red, green, blue
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [47:0]                          m_axis_tdata,  // red, green, blue, col, row, pad
    output logic                                 m_axis_tlast,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [leru_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [leru_pkg::DIM_W-1:0]      i_cfg_data
);

    localparam int AW = leru_pkg::ADDR_W;
    localparam int RW = leru_pkg::ROW_W;
    localparam int DW = leru_pkg::DIM_W;

    logic [DW-1:0] r_width;
    logic [DW-1:0] r_height;
    logic [AW-1:0] r_col;
    logic [RW-1:0] r_row;

    leru_pkg::t_pix mem_older [leru_pkg::MAX_WIDTH];
    leru_pkg::t_pix mem_newer [leru_pkg::MAX_WIDTH];

    logic           r_s1_valid;
    leru_pkg::t_pix r_s1_pix;
    logic [AW-1:0]  r_s1_x;
    logic [RW-1:0]  r_s1_y;
    leru_pkg::t_pix r_older_rd;
    leru_pkg::t_pix r_newer_rd;

    leru_pkg::t_win r_win;
    leru_pkg::t_win n_win;

    leru_pkg::t_res r_res [3];
    leru_pkg::t_res n_res [3];
    logic [2:0]     r_mask;
    logic [2:0]     n_mask;
    logic [2:0]     low_bit;
    logic           last_one;

    logic           in_fire;
    logic           s1_fire;
    logic           m_fire;
    logic [AW-1:0]  in_x;
    logic [RW-1:0]  in_y;
    logic [AW-1:0]  n_col;
    logic [RW-1:0]  n_row;
    leru_pkg::t_pix in_pix;
    leru_pkg::t_pix filt;
    logic           on_border;
    logic [1:0]     sel;

    // input side
    assign in_pix = s_axis_tdata;
    assign in_x = ({1'b0, r_col} >= r_width) ? AW'(r_width - DW'(1)) : r_col;
    assign in_y = ({1'b0, r_row} >= r_height) ? RW'(r_height - DW'(1)) : r_row;

    always_comb begin
        n_col = in_x + AW'(1);
        n_row = in_y;
        if (({1'b0, in_x} + DW'(1)) >= r_width) begin
            n_col = '0;
            n_row = in_y + RW'(1);
            if (({1'b0, in_y} + DW'(1)) >= r_height) begin
                n_row = '0;
            end
        end
    end

    // handshakes
    assign low_bit       = r_mask & (~r_mask + 3'd1);
    assign last_one      = (r_mask & (r_mask - 3'd1)) == 3'd0;
    assign m_axis_tvalid = |r_mask;
    assign m_fire        = m_axis_tvalid && m_axis_tready;
    assign s1_fire       = r_s1_valid && ((r_mask == 3'd0) || (m_fire && last_one));
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // size registers and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= leru_pkg::RESET_WIDTH;
            r_height <= leru_pkg::RESET_HEIGHT;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                leru_pkg::CFG_IDX_WIDTH: begin
                    r_width <= leru_pkg::clamp_dim(i_cfg_data, leru_pkg::MAX_WIDTH_V);
                    r_col   <= '0;
                    r_row   <= '0;
                end
                leru_pkg::CFG_IDX_HEIGHT: begin
                    r_height <= leru_pkg::clamp_dim(i_cfg_data, leru_pkg::MAX_HEIGHT_V);
                    r_col    <= '0;
                    r_row    <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_fire) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line stores
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_newer_rd       <= mem_newer[in_x];
            mem_newer[in_x]  <= in_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_older_rd <= mem_older[in_x];
        end
        if (s1_fire) begin
            mem_older[r_s1_x] <= r_newer_rd;
        end
    end

    // stage one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pix <= in_pix;
            r_s1_x   <= in_x;
            r_s1_y   <= in_y;
        end
    end

    // window shift and filter
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = r_older_rd;
        n_win[1][2] = r_newer_rd;
        n_win[2][2] = r_s1_pix;
    end

    assign filt      = leru_pkg::laplacian(n_win);
    assign on_border = (r_s1_x == AW'(1)) || (r_s1_y == RW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_fire) begin
            r_win <= n_win;
        end
    end

    // result slots
    always_comb begin
        n_mask[0] = (r_s1_y != '0) && (r_s1_x != '0);
        n_mask[1] = (r_s1_y != '0) && (({1'b0, r_s1_x} + DW'(1)) == r_width);
        n_mask[2] = ({1'b0, r_s1_y} + DW'(1)) == r_height;

        n_res[0].pix = on_border ? n_win[1][1] : filt;
        n_res[0].col = r_s1_x - AW'(1);
        n_res[0].row = r_s1_y - RW'(1);
        n_res[1].pix = r_newer_rd;
        n_res[1].col = r_s1_x;
        n_res[1].row = r_s1_y - RW'(1);
        n_res[2].pix = r_s1_pix;
        n_res[2].col = r_s1_x;
        n_res[2].row = r_s1_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (s1_fire) begin
            r_mask <= n_mask;
        end else if (m_fire) begin
            r_mask <= r_mask & ~low_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            for (int k = 0; k < 3; k++) begin
                r_res[k] <= n_res[k];
            end
        end
    end

    // output
    always_comb begin
        if (r_mask[0]) begin
            sel = 2'd0;
        end else if (r_mask[1]) begin
            sel = 2'd1;
        end else begin
            sel = 2'd2;
        end
    end

    assign m_axis_tlast = last_one;
    assign m_axis_tdata = {4'b0000, r_res[sel].row, r_res[sel].col,
                           r_res[sel].pix.blue, r_res[sel].pix.green, r_res[sel].pix.red};

endmodule

`default_nettype wire

FILE: design/leru_checker.sv
// port-level checks of the laplacian edge unit, bound to the top level
// depends on laplacian_edge_rgb_unit_defines.svh and leru_pkg
`default_nettype none

`include "laplacian_edge_rgb_unit_defines.svh"

module leru_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [23:0]                    s_axis_tdata,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [47:0]                    m_axis_tdata,
    input wire logic                           m_axis_tlast,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready,
    input wire logic [leru_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [leru_pkg::DIM_W-1:0]     i_cfg_data
);

    logic m_fire;
    logic unused_ok;

    assign m_fire    = m_axis_tvalid && m_axis_tready;
    assign unused_ok = ^{s_axis_tvalid, s_axis_tready, s_axis_tdata, i_cfg_valid,
                         o_cfg_ready, i_cfg_index, i_cfg_data};

    // a stalled result holds
    `LERU_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // results of one pixel follow each other without a gap
    `LERU_ASSERT(a_run_cont, i_clk, i_rst_n, m_fire && !m_axis_tlast |=> m_axis_tvalid, "gap inside a run of results")

    // within a run the row never goes back
    `LERU_ASSERT(a_run_row, i_clk, i_rst_n, m_fire && !m_axis_tlast |=> m_axis_tdata[43:34] >= $past(m_axis_tdata[43:34]), "row went back inside a run")

    // pad bits stay zero
    `LERU_ASSERT_NEVER(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[47:44] != 4'b0000), "nonzero pad bits")

endmodule

bind laplacian_edge_rgb_unit leru_checker u_leru_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_data    (i_cfg_data)
);

`default_nettype wire
